// ===== src/u16s_pkg.sv =====
// Shared types and constants for the UTF-16BE line splitter.
// No dependencies; every other file of the block imports this package.
package u16s_pkg;

   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_EOL  = 2'd1;
   localparam logic [1:0] KIND_EOT  = 2'd2;

   localparam logic [20:0] CP_NUL = 21'h00000;
   localparam logic [20:0] CP_LF  = 21'h0000a;
   localparam logic [20:0] CP_CR  = 21'h0000d;

   // unit[15:10] of a high surrogate
   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       source_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [20:0] code_point;
      logic        last;
   } rsp_type;

   // Results produced by one item: count of 0, 1 or 2, in order first, second
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } dec_out_type;

endpackage

// ===== src/u16s_decode.sv =====
// Decoder state and per-item decode: byte pairing, surrogate join, line logic.
// Depends on u16s_pkg.
module u16s_decode
   import u16s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     item,
   output dec_out_type results
);

   logic       byte_phase_ff, byte_phase_in;
   logic [7:0] held_high_byte_ff, held_high_byte_in;
   logic       surr_pending_ff, surr_pending_in;
   logic [9:0] surr_bits_ff, surr_bits_in;
   logic       skip_lf_ff, skip_lf_in;
   logic       line_has_ff, line_has_in;
   logic       finished_ff, finished_in;

   logic [15:0] unit;
   logic [20:0] cp;
   logic        have_cp;
   rsp_type     blank;

   always_comb begin
      unit = {held_high_byte_ff, item.data_byte};
      blank = '{kind: KIND_CHAR, code_point: '0, last: 1'b0};

      byte_phase_in     = byte_phase_ff;
      held_high_byte_in = held_high_byte_ff;
      surr_pending_in   = surr_pending_ff;
      surr_bits_in      = surr_bits_ff;
      skip_lf_in        = skip_lf_ff;
      line_has_in       = line_has_ff;
      finished_in       = finished_ff;

      results.count  = 2'd0;
      results.first  = blank;
      results.second = blank;
      have_cp        = 1'b0;
      cp             = '0;

      if (finished_ff) begin
         // drop everything until reset
      end else if (item.source_end) begin
         if (line_has_ff) begin
            results.count        = 2'd2;
            results.first.kind   = KIND_EOL;
            results.second.kind  = KIND_EOT;
            results.second.last  = 1'b1;
         end else begin
            results.count       = 2'd1;
            results.first.kind  = KIND_EOT;
            results.first.last  = 1'b1;
         end
         byte_phase_in     = 1'b0;
         held_high_byte_in = '0;
         surr_pending_in   = 1'b0;
         surr_bits_in      = '0;
         skip_lf_in        = 1'b0;
         line_has_in       = 1'b0;
         finished_in       = 1'b1;
      end else if (!byte_phase_ff) begin
         held_high_byte_in = item.data_byte;
         byte_phase_in     = 1'b1;
      end else begin
         byte_phase_in = 1'b0;
         if (surr_pending_ff) begin
            surr_pending_in = 1'b0;
            surr_bits_in    = '0;
            cp      = {5'(surr_bits_ff[9:6]) + 5'd1, surr_bits_ff[5:0], unit[9:0]};
            have_cp = 1'b1;
         end else if (unit[15:10] == HIGH_SURR_TAG) begin
            surr_pending_in = 1'b1;
            surr_bits_in    = unit[9:0];
         end else begin
            cp      = {5'd0, unit};
            have_cp = 1'b1;
         end
      end

      if (have_cp) begin
         skip_lf_in         = 1'b0;
         results.first.last = 1'b1;
         if (skip_lf_ff && cp == CP_LF) begin
            // swallow LF right after CR
         end else if (cp == CP_NUL) begin
            results.count = 2'd1;
            if (line_has_ff) begin
               line_has_in        = 1'b0;
               results.first.kind = KIND_EOL;
            end else begin
               finished_in        = 1'b1;
               results.first.kind = KIND_EOT;
            end
         end else if (cp == CP_LF || cp == CP_CR) begin
            results.count      = 2'd1;
            results.first.kind = KIND_EOL;
            line_has_in        = 1'b0;
            skip_lf_in         = (cp == CP_CR);
         end else begin
            results.count            = 2'd1;
            results.first.kind       = KIND_CHAR;
            results.first.code_point = cp;
            line_has_in              = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff     <= 1'b0;
         held_high_byte_ff <= '0;
         surr_pending_ff   <= 1'b0;
         surr_bits_ff      <= '0;
         skip_lf_ff        <= 1'b0;
         line_has_ff       <= 1'b0;
         finished_ff       <= 1'b0;
      end else if (step) begin
         byte_phase_ff     <= byte_phase_in;
         held_high_byte_ff <= held_high_byte_in;
         surr_pending_ff   <= surr_pending_in;
         surr_bits_ff      <= surr_bits_in;
         skip_lf_ff        <= skip_lf_in;
         line_has_ff       <= line_has_in;
         finished_ff       <= finished_in;
      end
   end

endmodule

// ===== src/u16s_rsp_fifo.sv =====
// Four-entry result queue that takes up to two results a cycle, gives one.
// Depends on u16s_pkg.
module u16s_rsp_fifo
   import u16s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  dec_out_type push_data,
   output logic        room2,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   rsp_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]       count_ff, count_in;
   logic [1:0]             n_push;
   logic                   pop;
   logic [FIFO_AW-1:0]     wr_next;

   assign n_push    = push ? push_data.count : 2'd0;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign room2     = (count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(n_push);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data.first;
      end
      if (n_push == 2'd2) begin
         entry_ff[wr_next] <= push_data.second;
      end
   end

endmodule

// ===== src/utf16be_line_splitter.sv =====
// Top level of the UTF-16BE line splitter: input register, decoder, result queue.
// Depends on u16s_pkg, u16s_decode and u16s_rsp_fifo.
//
//   channel | ports                          | moves
//   req     | req_valid, req_ready, req_data | one source byte or end mark
//   rsp     | rsp_valid, rsp_ready, rsp_data | one character, end of line or end of text
//
// One item per cycle while the queue has room: a transfer lands in the input
// register, is decoded from there and its 0..2 results enter a four-entry
// queue that drives rsp. Stall: the input register holds while the queue has
// fewer than two free entries. Reset is synchronous and clears the decoder
// state, queue pointers and input valid; no clearing pass.
module utf16be_line_splitter
   import u16s_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_item_ff;
   logic        room2;
   logic        step;
   dec_out_type dec_out;

   assign step        = s1_valid_ff && room2;
   assign req_ready   = !s1_valid_ff || step;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_data;
      end
   end

   u16s_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (s1_item_ff),
      .results (dec_out)
   );

   u16s_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (dec_out),
      .room2     (room2),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/u16s_checker.sv =====
// Port-level checks for the UTF-16BE line splitter, bound to the top level.
// Depends on u16s_pkg and utf16be_line_splitter.
module u16s_checker
   import u16s_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic eot_seen_ff;

   // mark the end-of-text transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         eot_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_data.kind == KIND_EOT) begin
         eot_seen_ff <= 1'b1;
      end
   end

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_eot_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_EOT |-> rsp_data.last)
      else $error("end of text not marked last");

   a_cp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_CHAR |-> rsp_data.code_point == '0)
      else $error("line mark carries a code point");

   a_quiet_after_eot: assert property (@(posedge clock) disable iff (reset)
      eot_seen_ff |-> !rsp_valid)
      else $error("result after end of text");

endmodule

bind utf16be_line_splitter u16s_checker u_checker (.*);
